// ----- hw/rtl/fqr_pkg.sv -----
// Shared types and constants for the id-removable FIFO queue.
`default_nettype none
package fqr_pkg;

  localparam int DEPTH = 16;
  localparam int ID_W = 16;
  localparam int LIM_W = 5;
  localparam int OCNT_W = 5;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CMP_W = (CNT_W > LIM_W) ? CNT_W : LIM_W;
  localparam logic [LIM_W-1:0] LIMIT_RESET = LIM_W'(16);

  typedef enum logic [1:0] {
    CMD_PUSH   = 2'd0,
    CMD_POP    = 2'd1,
    CMD_PEEK   = 2'd2,
    CMD_REMOVE = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;

  typedef struct packed {
    logic valid;
    logic write;
    logic shift_all;
    logic remove;
  } cell_ctl_t;

endpackage
`default_nettype wire

// ----- hw/rtl/fqr_cell.sv -----
// One queue slot: holds an id, compares it, shifts toward the head.
`default_nettype none
module fqr_cell (
  input  wire logic                    clk,
  input  wire fqr_pkg::cell_ctl_t      ctl,
  input  wire logic [fqr_pkg::ID_W-1:0] in_id,
  input  wire logic [fqr_pkg::ID_W-1:0] next_data,
  input  wire logic                    found_in,
  output logic                         found_out,
  output logic [fqr_pkg::ID_W-1:0]     data
);

  logic                     match;
  logic                     shift;
  logic [fqr_pkg::ID_W-1:0] data_next;

  assign match     = ctl.valid && ctl.remove && (data == in_id);
  assign found_out = found_in || match;
  assign shift     = ctl.shift_all || found_out;

  always_comb begin
    priority if (ctl.write) begin
      data_next = in_id;
    end else if (shift) begin
      data_next = next_data;
    end else begin
      data_next = data;
    end
  end

  always_ff @(posedge clk) begin
    data <= data_next;
  end

endmodule
`default_nettype wire

// ----- hw/rtl/fifo_queue_with_remove_by_id_top.sv -----
// Top level of the id-removable FIFO queue: request decode, cell row, result register.
//
//  channel | handshake            | word
//  --------+----------------------+---------------------------------
//  cfg     | cfg_valid/cfg_ready  | queue_limit
//  in      | in_valid/in_ready    | command, item_id
//  out     | out_valid/out_ready  | status, out_id, out_count
//
// One request a cycle while in_ready is high: the cells compare and shift in the cycle the word
// is accepted, and the result is captured in the output register at the same edge.
// The oldest-match search ripples through the row of DEPTH cells.
// in_ready drops only while a result waits and out_ready is low.
// Reset empties the queue and sets the queue limit to 16; cfg_ready is always high.
`default_nettype none
module fifo_queue_with_remove_by_id_top (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       cfg_valid,
  output logic                            cfg_ready,
  input  wire logic [fqr_pkg::LIM_W-1:0]  queue_limit,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic [1:0]                 command,
  input  wire logic [fqr_pkg::ID_W-1:0]   item_id,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic [1:0]                      status,
  output logic [fqr_pkg::ID_W-1:0]        out_id,
  output logic [fqr_pkg::OCNT_W-1:0]      out_count
);

  logic [fqr_pkg::LIM_W-1:0] limit;
  logic [fqr_pkg::CNT_W-1:0] count;
  logic [fqr_pkg::CNT_W-1:0] count_next;
  logic                      in_fire;
  fqr_pkg::cmd_t             cmd;
  logic                      full;
  logic                      empty;
  logic                      found;
  fqr_pkg::status_t          status_next;
  logic [fqr_pkg::ID_W-1:0]  id_next;
  logic                      do_push;
  logic                      do_pop;
  logic                      do_remove;

  fqr_pkg::cell_ctl_t        ctl [fqr_pkg::DEPTH];
  logic [fqr_pkg::ID_W-1:0]  cell_data [fqr_pkg::DEPTH];
  logic [fqr_pkg::DEPTH:0]   found_chain;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid || out_ready;
  assign in_fire   = in_valid && in_ready;
  assign cmd       = fqr_pkg::cmd_t'(command);

  assign empty = (count == '0);
  assign full  = (fqr_pkg::CMP_W'(count) >= fqr_pkg::CMP_W'(limit)) ||
                 (count >= fqr_pkg::CNT_W'(fqr_pkg::DEPTH));

  assign do_push   = in_fire && (cmd == fqr_pkg::CMD_PUSH) && !full;
  assign do_pop    = in_fire && (cmd == fqr_pkg::CMD_POP) && !empty;
  assign do_remove = in_fire && (cmd == fqr_pkg::CMD_REMOVE);

  assign found_chain[0] = 1'b0;
  assign found = found_chain[fqr_pkg::DEPTH];

  for (genvar i = 0; i < fqr_pkg::DEPTH; i++) begin : g_cell
    logic [fqr_pkg::ID_W-1:0] nd;
    if (i == fqr_pkg::DEPTH - 1) begin : g_last
      assign nd = cell_data[i];
    end else begin : g_mid
      assign nd = cell_data[i+1];
    end
    assign ctl[i].valid     = (fqr_pkg::CNT_W'(i) < count);
    assign ctl[i].write     = do_push && (count == fqr_pkg::CNT_W'(i));
    assign ctl[i].shift_all = do_pop;
    assign ctl[i].remove    = do_remove;
    fqr_cell u_cell (
      .clk       (clk),
      .ctl       (ctl[i]),
      .in_id     (item_id),
      .next_data (nd),
      .found_in  (found_chain[i]),
      .found_out (found_chain[i+1]),
      .data      (cell_data[i])
    );
  end

  always_comb begin
    status_next = fqr_pkg::ST_OK;
    id_next     = '0;
    count_next  = count;
    unique case (cmd)
      fqr_pkg::CMD_PUSH: begin
        if (full) begin
          status_next = fqr_pkg::ST_FULL;
        end else begin
          id_next    = item_id;
          count_next = fqr_pkg::CNT_W'(count + 1'b1);
        end
      end
      fqr_pkg::CMD_POP: begin
        if (empty) begin
          status_next = fqr_pkg::ST_EMPTY;
        end else begin
          id_next    = cell_data[0];
          count_next = fqr_pkg::CNT_W'(count - 1'b1);
        end
      end
      fqr_pkg::CMD_PEEK: begin
        if (empty) begin
          status_next = fqr_pkg::ST_EMPTY;
        end else begin
          id_next = cell_data[0];
        end
      end
      fqr_pkg::CMD_REMOVE: begin
        if (found) begin
          id_next    = item_id;
          count_next = fqr_pkg::CNT_W'(count - 1'b1);
        end else begin
          status_next = fqr_pkg::ST_NOTFOUND;
        end
      end
      default: begin
        status_next = fqr_pkg::ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      limit     <= fqr_pkg::LIMIT_RESET;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        limit <= queue_limit;
      end
      if (in_fire) begin
        count     <= count_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      status    <= status_next;
      out_id    <= id_next;
      out_count <= fqr_pkg::OCNT_W'(count_next);
    end
  end

  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    do_push |=> (count == fqr_pkg::CNT_W'($past(count) + 1'b1)))
    else $error("accepted push did not grow the queue");

  a_peek_keeps: assert property (@(posedge clk) disable iff (rst)
    (in_fire && (cmd == fqr_pkg::CMD_PEEK)) |=> (count == $past(count)))
    else $error("peek changed the queue count");

  a_fail_zero_id: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status != fqr_pkg::ST_OK)) |-> (out_id == '0))
    else $error("failed request returned a nonzero id");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (fqr_pkg::CNT_W'(out_count) == count))
    else $error("reported count differs from queue count");

endmodule
`default_nettype wire
